[design/aabb_rotate_translate_bounds_defines.svh]
// ----------------------------------------------------------------------------
// aabb rotate translate bounds: assertion macros
// concurrent assertion wrappers for the checks of the block
// ----------------------------------------------------------------------------
`ifndef AABB_ROTATE_TRANSLATE_BOUNDS_DEFINES_SVH
`define AABB_ROTATE_TRANSLATE_BOUNDS_DEFINES_SVH

// same-cycle implication
`define ARBT_ASSERT_IMPL(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ARBT_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/arbt_pkg.sv]
// ----------------------------------------------------------------------------
// arbt_pkg
// shared constants, types and sine seed helper for the bounds transform
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package arbt_pkg;

    localparam int TRIG_W       = 17;
    localparam int ANGLE_FRAC   = 14;
    localparam int SCALE_FRAC   = 8;
    localparam int QUARTER_TURN = 16384;
    localparam int POLY_A       = 25736;
    localparam int POLY_B       = 10512;
    localparam int POLY_C       = 1160;
    localparam int N_TRIG       = 6;
    localparam int N_CORNER     = 8;
    localparam int FIFO_DEPTH   = 4;
    localparam int FIFO_AW      = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW      = $clog2(FIFO_DEPTH + 1);

    typedef struct packed {
        logic        neg;
        logic [14:0] z;
    } trig_seed_t;

    // quadrant fold: position within the quarter wave and sign of the result
    function automatic trig_seed_t trig_seed(input logic [15:0] a);
        trig_seed_t sd;
        sd.neg = a[15];
        sd.z   = a[14] ? 15'(QUARTER_TURN - int'(a[13:0])) : 15'(a[13:0]);
        return sd;
    endfunction

endpackage

[design/aabb_rotate_translate_bounds.sv]
// ----------------------------------------------------------------------------
// aabb_rotate_translate_bounds
// world bounds of a scaled, rotated and translated local box
// ----------------------------------------------------------------------------
// path: each box crosses the front pipeline, the queue and the back pipeline to m_tvalid
// throughput: one box per cycle; front and back pipelines each stall as a whole
// the four-entry queue lets the front keep taking boxes while the output stalls, until it fills
// reset: asynchronous, clears all valid bits and queue pointers, no clearing pass
`timescale 1ns / 1ps

module aabb_rotate_translate_bounds
    import arbt_pkg::*;
#(
    parameter int COORD_WIDTH = 32
)
(
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    s_tvalid,
    output logic                                    s_tready,
    // box_min_x/y/z, box_max_x/y/z, scale_factor, rotation_angles, origin_x/y/z
    input  logic [((9*COORD_WIDTH+64+7)/8)*8-1:0]   s_tdata,
    output logic                                    m_tvalid,
    input  logic                                    m_tready,
    // world_min_x/y/z, world_max_x/y/z
    output logic [((6*COORD_WIDTH+7)/8)*8-1:0]      m_tdata,
    // bounds_valid
    output logic                                    m_tuser
);

    localparam int IN_W  = ((9*COORD_WIDTH + 64 + 7) / 8) * 8;
    localparam int OUT_W = ((6*COORD_WIDTH + 7) / 8) * 8;
    localparam int PW    = 9*COORD_WIDTH + 1 + N_TRIG*TRIG_W;

    logic          push;
    logic [PW-1:0] push_data;
    logic          full;
    logic          pop;
    logic [PW-1:0] pop_data;
    logic          empty;

    arbt_front #(
        .CW   (COORD_WIDTH),
        .IN_W (IN_W),
        .PW   (PW)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .push      (push),
        .push_data (push_data),
        .full      (full)
    );

    arbt_fifo #(
        .W (PW)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (empty)
    );

    arbt_back #(
        .CW    (COORD_WIDTH),
        .PW    (PW),
        .OUT_W (OUT_W)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .empty    (empty),
        .pop      (pop),
        .pop_data (pop_data),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

[design/arbt_front.sv]
// ----------------------------------------------------------------------------
// arbt_front
// accepts boxes, scales the local corners and evaluates the six sine/cosine
// coefficients in a five stage pipeline, then pushes into the queue
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module arbt_front
    import arbt_pkg::*;
#(
    parameter int CW   = 32,
    parameter int IN_W = 352,
    parameter int PW   = 391
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  logic [IN_W-1:0] s_tdata,
    output logic            push,
    output logic [PW-1:0]   push_data,
    input  logic            full
);

    logic                      adv;
    logic [4:0]                v_reg;
    logic signed [CW+16:0]     prod_reg [6];
    trig_seed_t                seed_reg [4][N_TRIG];
    logic signed [CW-1:0]      org_reg  [5][3];
    logic signed [CW-1:0]      p_reg    [4][6];
    logic [3:0]                ok_reg;
    logic [14:0]               z2_reg   [2][N_TRIG];
    logic [13:0]               t1_reg   [N_TRIG];
    logic [14:0]               t2_reg   [N_TRIG];
    logic signed [TRIG_W-1:0]  coef_reg [N_TRIG];

    logic signed [CW+16:0]     prod_c   [6];
    trig_seed_t                seed_c   [N_TRIG];
    logic signed [CW-1:0]      p_c      [6];
    logic                      ok_c;
    logic [14:0]               z2_c     [N_TRIG];
    logic [13:0]               t1_c     [N_TRIG];
    logic [14:0]               t2_c     [N_TRIG];
    logic signed [TRIG_W-1:0]  coef_c   [N_TRIG];

    assign adv      = !v_reg[4] || !full;
    assign s_tready = adv;
    assign push     = v_reg[4] && !full;

    // scaling products and quadrant fold of the angles
    always_comb
    begin
        logic signed [16:0] scale_s;
        logic [15:0]        ang;
        scale_s = {1'b0, s_tdata[6*CW +: 16]};
        for (int k = 0; k < 6; k++)
        begin
            prod_c[k] = $signed(s_tdata[k*CW +: CW]) * scale_s;
        end
        for (int k = 0; k < N_TRIG; k++)
        begin
            ang = s_tdata[6*CW + 16 + 16*(k >> 1) +: 16];
            // even slots are cosines: quarter turn ahead
            if (k[0] == 1'b0)
            begin
                ang = ang + 16'(QUARTER_TURN);
            end
            seed_c[k] = trig_seed(ang);
        end
    end

    // rounding of the scaled corners and the polynomial steps
    always_comb
    begin
        logic signed [CW+16:0] rs;
        logic [29:0]           zz;
        logic [25:0]           cz;
        logic [28:0]           zt;
        logic [29:0]           st;
        ok_c = 1'b1;
        for (int k = 0; k < 6; k++)
        begin
            rs     = (prod_reg[k] + (CW+17)'(1 << (SCALE_FRAC - 1))) >>> SCALE_FRAC;
            p_c[k] = rs[CW-1:0];
            if (!((rs[CW+16:CW-1] == '0) || (rs[CW+16:CW-1] == '1)))
            begin
                ok_c = 1'b0;
            end
        end
        for (int k = 0; k < N_TRIG; k++)
        begin
            zz        = seed_reg[0][k].z * seed_reg[0][k].z;
            z2_c[k]   = zz[28:14];
            cz        = 11'(POLY_C) * z2_reg[0][k];
            t1_c[k]   = 14'(POLY_B) - 14'(cz >> ANGLE_FRAC);
            zt        = z2_reg[1][k] * t1_reg[k];
            t2_c[k]   = 15'(POLY_A) - 15'(zt >> ANGLE_FRAC);
            st        = seed_reg[3][k].z * t2_reg[k];
            coef_c[k] = seed_reg[3][k].neg ? -$signed({1'b0, st[29:14]})
                                           : $signed({1'b0, st[29:14]});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (adv)
        begin
            v_reg <= {v_reg[3:0], s_tvalid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < 6; k++)
            begin
                prod_reg[k] <= prod_c[k];
                p_reg[0][k] <= p_c[k];
                for (int s = 1; s < 4; s++)
                begin
                    p_reg[s][k] <= p_reg[s-1][k];
                end
            end
            ok_reg <= {ok_reg[2:0], ok_c};
            for (int i = 0; i < 3; i++)
            begin
                org_reg[0][i] <= s_tdata[6*CW + 64 + i*CW +: CW];
                for (int s = 1; s < 5; s++)
                begin
                    org_reg[s][i] <= org_reg[s-1][i];
                end
            end
            for (int k = 0; k < N_TRIG; k++)
            begin
                seed_reg[0][k] <= seed_c[k];
                for (int s = 1; s < 4; s++)
                begin
                    seed_reg[s][k] <= seed_reg[s-1][k];
                end
                z2_reg[0][k] <= z2_c[k];
                z2_reg[1][k] <= z2_reg[0][k];
                t1_reg[k]    <= t1_c[k];
                t2_reg[k]    <= t2_c[k];
                coef_reg[k]  <= coef_c[k];
            end
        end
    end

    always_comb
    begin
        push_data = '0;
        for (int k = 0; k < 6; k++)
        begin
            push_data[k*CW +: CW] = p_reg[3][k];
        end
        for (int i = 0; i < 3; i++)
        begin
            push_data[(6+i)*CW +: CW] = org_reg[4][i];
        end
        push_data[9*CW] = ok_reg[3];
        for (int k = 0; k < N_TRIG; k++)
        begin
            push_data[9*CW + 1 + k*TRIG_W +: TRIG_W] = coef_reg[k];
        end
    end

endmodule

[design/arbt_fifo.sv]
// ----------------------------------------------------------------------------
// arbt_fifo
// short register queue between the front and back pipelines
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "aabb_rotate_translate_bounds_defines.svh"

module arbt_fifo
    import arbt_pkg::*;
#(
    parameter int W = 391
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic [W-1:0] push_data,
    output logic         full,
    input  logic         pop,
    output logic [W-1:0] pop_data,
    output logic         empty
);

    logic [W-1:0]         mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   wr_ptr_reg;
    logic [FIFO_AW-1:0]   rd_ptr_reg;
    logic [FIFO_CW-1:0]   count_reg;
    logic [FIFO_CW-1:0]   count_next;

    assign full     = (count_reg == FIFO_CW'(FIFO_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    `ARBT_ASSERT_IMPL(a_no_overflow, clk, rst_n, push, !full, "push into a full queue")
    `ARBT_ASSERT_IMPL(a_no_underflow, clk, rst_n, pop, !empty, "pop from an empty queue")
    `ARBT_ASSERT_NEXT(a_count_up, clk, rst_n, push && !pop, count_reg == $past(count_reg) + 1'b1, "queue count did not step up")

endmodule

[design/arbt_back.sv]
// ----------------------------------------------------------------------------
// arbt_back
// rotates the eight corners in parallel lanes, translates, checks range and
// reduces to the world minimum and maximum with an output register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module arbt_back
    import arbt_pkg::*;
#(
    parameter int CW    = 32,
    parameter int PW    = 391,
    parameter int OUT_W = 192
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             empty,
    output logic             pop,
    input  logic [PW-1:0]    pop_data,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata,
    output logic             m_tuser
);

    localparam int IW = CW + 3;
    localparam int MW = IW + TRIG_W + 1;

    typedef logic signed [TRIG_W-1:0] coef_t;

    logic                 adv;
    logic [4:0]           vb_reg;
    logic                 out_valid_reg;
    logic [PW-1:0]        b0_reg;

    logic signed [CW-1:0] lo_c [3];
    logic signed [CW-1:0] hi_c [3];
    logic signed [CW-1:0] org_c [3];
    coef_t                coef_c [N_TRIG];

    logic signed [IW-1:0] px1_reg [N_CORNER];
    logic signed [IW-1:0] y1_reg  [N_CORNER];
    logic signed [IW-1:0] z1_reg  [N_CORNER];
    logic signed [IW-1:0] y2_reg  [N_CORNER];
    logic signed [IW-1:0] x2_reg  [N_CORNER];
    logic signed [IW-1:0] z2_reg  [N_CORNER];
    logic signed [IW-1:0] x3_reg  [N_CORNER];
    logic signed [IW-1:0] y3_reg  [N_CORNER];
    logic signed [IW-1:0] z3_reg  [N_CORNER];
    coef_t                cy_reg, sy_reg;
    coef_t                cz_reg [2];
    coef_t                sz_reg [2];
    logic signed [CW-1:0] org_reg [3][3];
    logic [2:0]           ok_reg;

    logic signed [IW-1:0] y1_c [N_CORNER];
    logic signed [IW-1:0] z1_c [N_CORNER];
    logic signed [IW-1:0] x2_c [N_CORNER];
    logic signed [IW-1:0] z2_c [N_CORNER];
    logic signed [IW-1:0] x3_c [N_CORNER];
    logic signed [IW-1:0] y3_c [N_CORNER];
    logic signed [CW-1:0] w_c  [3][N_CORNER];
    logic                 wok_c;

    logic signed [CW-1:0] mn_reg [3][4];
    logic signed [CW-1:0] mx_reg [3][4];
    logic signed [CW-1:0] mn_c   [3][4];
    logic signed [CW-1:0] mx_c   [3][4];

    logic signed [CW-1:0] omin_reg [3];
    logic signed [CW-1:0] omax_reg [3];
    logic                 out_ok_reg;
    logic signed [CW-1:0] omin_c [3];
    logic signed [CW-1:0] omax_c [3];

    // a*u +/- b*v at Q.22, rounded back to Q.8
    function automatic logic signed [IW-1:0] rot(input coef_t a, input logic signed [IW-1:0] u,
                                                 input coef_t b, input logic signed [IW-1:0] v,
                                                 input logic sub);
        logic signed [MW-1:0] pa;
        logic signed [MW-1:0] pb;
        logic signed [MW-1:0] acc;
        pa  = a * u;
        pb  = b * v;
        acc = sub ? (pa - pb) : (pa + pb);
        acc = (acc + MW'(1 << (ANGLE_FRAC - 1))) >>> ANGLE_FRAC;
        return acc[IW-1:0];
    endfunction

    assign adv      = !out_valid_reg || m_tready;
    assign pop      = adv && !empty;
    assign m_tvalid = out_valid_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            lo_c[i]  = b0_reg[i*CW +: CW];
            hi_c[i]  = b0_reg[(3+i)*CW +: CW];
            org_c[i] = b0_reg[(6+i)*CW +: CW];
        end
        for (int k = 0; k < N_TRIG; k++)
        begin
            coef_c[k] = b0_reg[9*CW + 1 + k*TRIG_W +: TRIG_W];
        end
    end

    // rotation lanes: x axis, then y, then z, one stage each
    always_comb
    begin
        logic signed [IW-1:0] py;
        logic signed [IW-1:0] pz;
        logic signed [IW:0]   w;
        wok_c = ok_reg[2];
        for (int c = 0; c < N_CORNER; c++)
        begin
            py      = IW'(c[1] ? hi_c[1] : lo_c[1]);
            pz      = IW'(c[2] ? hi_c[2] : lo_c[2]);
            y1_c[c] = rot(coef_c[0], py, coef_c[1], pz, 1'b1);
            z1_c[c] = rot(coef_c[1], py, coef_c[0], pz, 1'b0);
            x2_c[c] = rot(cy_reg, px1_reg[c], sy_reg, z1_reg[c], 1'b0);
            z2_c[c] = rot(cy_reg, z1_reg[c], sy_reg, px1_reg[c], 1'b1);
            x3_c[c] = rot(cz_reg[1], x2_reg[c], sz_reg[1], y2_reg[c], 1'b1);
            y3_c[c] = rot(sz_reg[1], x2_reg[c], cz_reg[1], y2_reg[c], 1'b0);
            for (int i = 0; i < 3; i++)
            begin
                w = (i == 0) ? ((IW+1)'(x3_reg[c]) + (IW+1)'(org_reg[2][0]))
                  : (i == 1) ? ((IW+1)'(y3_reg[c]) + (IW+1)'(org_reg[2][1]))
                             : ((IW+1)'(z3_reg[c]) + (IW+1)'(org_reg[2][2]));
                w_c[i][c] = w[CW-1:0];
                if (!((w[IW:CW-1] == '0) || (w[IW:CW-1] == '1)))
                begin
                    wok_c = 1'b0;
                end
            end
        end
    end

    // first level of the min/max tree, then the last two levels
    always_comb
    begin
        logic signed [CW-1:0] a0;
        logic signed [CW-1:0] a1;
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 4; j++)
            begin
                mn_c[i][j] = (w_c[i][2*j+1] < w_c[i][2*j]) ? w_c[i][2*j+1] : w_c[i][2*j];
                mx_c[i][j] = (w_c[i][2*j+1] > w_c[i][2*j]) ? w_c[i][2*j+1] : w_c[i][2*j];
            end
            a0        = (mn_reg[i][1] < mn_reg[i][0]) ? mn_reg[i][1] : mn_reg[i][0];
            a1        = (mn_reg[i][3] < mn_reg[i][2]) ? mn_reg[i][3] : mn_reg[i][2];
            omin_c[i] = (a1 < a0) ? a1 : a0;
            a0        = (mx_reg[i][1] > mx_reg[i][0]) ? mx_reg[i][1] : mx_reg[i][0];
            a1        = (mx_reg[i][3] > mx_reg[i][2]) ? mx_reg[i][3] : mx_reg[i][2];
            omax_c[i] = (a1 > a0) ? a1 : a0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vb_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            vb_reg        <= {vb_reg[3:0], !empty};
            out_valid_reg <= vb_reg[4];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b0_reg <= pop_data;
            for (int c = 0; c < N_CORNER; c++)
            begin
                px1_reg[c] <= IW'(c[0] ? hi_c[0] : lo_c[0]);
                y1_reg[c]  <= y1_c[c];
                z1_reg[c]  <= z1_c[c];
                y2_reg[c]  <= y1_reg[c];
                x2_reg[c]  <= x2_c[c];
                z2_reg[c]  <= z2_c[c];
                x3_reg[c]  <= x3_c[c];
                y3_reg[c]  <= y3_c[c];
                z3_reg[c]  <= z2_reg[c];
            end
            cy_reg    <= coef_c[2];
            sy_reg    <= coef_c[3];
            cz_reg[0] <= coef_c[4];
            sz_reg[0] <= coef_c[5];
            cz_reg[1] <= cz_reg[0];
            sz_reg[1] <= sz_reg[0];
            ok_reg    <= {ok_reg[1:0], b0_reg[9*CW]};
            for (int i = 0; i < 3; i++)
            begin
                org_reg[0][i] <= org_c[i];
                org_reg[1][i] <= org_reg[0][i];
                org_reg[2][i] <= org_reg[1][i];
                for (int j = 0; j < 4; j++)
                begin
                    mn_reg[i][j] <= mn_c[i][j];
                    mx_reg[i][j] <= mx_c[i][j];
                end
            end
            out_ok_reg <= wok_c;
            // overflowed transactions report all-zero bounds
            for (int i = 0; i < 3; i++)
            begin
                omin_reg[i] <= out_ok_reg ? omin_c[i] : '0;
                omax_reg[i] <= out_ok_reg ? omax_c[i] : '0;
            end
        end
    end

    // out_ok_reg sits beside the min/max level; the flag follows it one stage on
    logic out_flag_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_flag_reg <= out_ok_reg;
        end
    end

    always_comb
    begin
        m_tdata = '0;
        for (int i = 0; i < 3; i++)
        begin
            m_tdata[i*CW +: CW]     = omin_reg[i];
            m_tdata[(3+i)*CW +: CW] = omax_reg[i];
        end
        m_tuser = out_flag_reg;
    end

endmodule
